### design/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg: shared types and constants for the heater hysteresis control
// Item, result and configuration layouts, register indexes and the
// altitude-indexed threshold tables (0.1 degC).
// ----------------------------------------------------------------------------
package hhc_pkg;

  // Number of altitude entries in use; an index at or above it selects entry 0
  localparam logic [2:0] ALTITUDE_LEVELS = 3'd4;

  localparam logic [10:0] PROTECT_TEMP_RESET = 11'd950;

  localparam logic [10:0] TBL_ON_NORMAL  [4] = '{11'd750, 11'd680, 11'd680, 11'd680};
  localparam logic [10:0] TBL_OFF_NORMAL [4] = '{11'd850, 11'd740, 11'd740, 11'd740};
  localparam logic [10:0] TBL_ON_BOOST   [4] = '{11'd750, 11'd730, 11'd730, 11'd730};
  localparam logic [10:0] TBL_OFF_BOOST  [4] = '{11'd900, 11'd790, 11'd790, 11'd790};

  typedef enum logic [1:0] {
    REG_HEATING_ENABLE = 2'd0,
    REG_BOOST_MODE     = 2'd1,
    REG_ALTITUDE_LEVEL = 2'd2,
    REG_PROTECT_TEMP   = 2'd3
  } hhc_reg_t;

  typedef struct packed {
    logic        heating_enable;
    logic        boost_mode;
    logic [1:0]  altitude_level;
    logic [10:0] protect_temp;
  } hhc_cfg_t;

  // Declared high field first so that tank_temp sits in the low bits
  typedef struct packed {
    logic               cancel_delay;
    logic               flushing;
    logic               dispensing;
    logic               tank_error;
    logic               level_low;
    logic signed [11:0] tank_temp;
  } hhc_item_t;

  typedef struct packed {
    logic [2:0]  startup_left;
    logic [5:0]  delay_left;
    logic [10:0] off_threshold;
    logic [10:0] on_threshold;
    logic        heater_on;
  } hhc_result_t;

endpackage

### design/hhc_core.sv
// ----------------------------------------------------------------------------
// hhc_core: one-tick evaluation of the heater control
// Delay cancel, startup countdown, threshold lookup, level-recovery delay,
// interlocks, hysteresis and over-temperature cutoff, all combinational.
// ----------------------------------------------------------------------------
module hhc_core
  import hhc_pkg::*;
#(
  parameter int LEVEL_DELAY_TICKS = 60,
  parameter int SW                = 3,
  parameter int DW                = 6
) (
  input  hhc_cfg_t          cfg,
  input  hhc_item_t         item,
  input  logic [SW-1:0]     startup,
  input  logic [DW-1:0]     delay,
  input  logic              heating,
  input  logic              prev_level_low,
  output logic [SW-1:0]     startup_next,
  output logic [DW-1:0]     delay_next,
  output logic              heating_next,
  output logic              prev_level_low_next,
  output hhc_result_t       result
);

  logic [1:0]         idx;
  logic [10:0]        on_t;
  logic [10:0]        off_t;
  logic [DW-1:0]      delay_c;
  logic [DW-1:0]      delay_r;
  logic signed [12:0] temp_x;
  logic signed [12:0] on_x;
  logic signed [12:0] off_x;
  logic signed [12:0] prot_x;
  logic               blocked;

  always_comb begin
    delay_c = item.cancel_delay ? '0 : delay;

    if (!item.flushing && (startup != '0)) begin
      startup_next = startup - SW'(1);
    end else begin
      startup_next = startup;
    end

    idx   = ({1'b0, cfg.altitude_level} >= ALTITUDE_LEVELS) ? 2'd0 : cfg.altitude_level;
    on_t  = cfg.boost_mode ? TBL_ON_BOOST[idx]  : TBL_ON_NORMAL[idx];
    off_t = cfg.boost_mode ? TBL_OFF_BOOST[idx] : TBL_OFF_NORMAL[idx];

    // level leaving low re-arms the delay, after any cancel
    delay_r = (prev_level_low && !item.level_low) ? DW'(LEVEL_DELAY_TICKS) : delay_c;
    prev_level_low_next = item.level_low;

    temp_x = {item.tank_temp[11], item.tank_temp};
    on_x   = signed'({2'b00, on_t});
    off_x  = signed'({2'b00, off_t});
    prot_x = signed'({2'b00, cfg.protect_temp});

    blocked = (startup_next != '0) || !cfg.heating_enable || item.level_low ||
              item.tank_error || item.dispensing || item.flushing || (temp_x >= prot_x);

    delay_next = delay_r;
    if (delay_r != '0) begin
      delay_next   = delay_r - DW'(1);
      heating_next = 1'b0;
    end else if (blocked) begin
      heating_next = 1'b0;
    end else if (heating) begin
      heating_next = !(off_x <= temp_x);
    end else begin
      heating_next = (on_x >= temp_x);
    end

    result.heater_on     = heating_next;
    result.on_threshold  = on_t;
    result.off_threshold = off_t;
    result.delay_left    = delay_next[5:0];
    result.startup_left  = startup_next[2:0];
  end

endmodule

### design/heater_hysteresis_control_unit.sv
// ----------------------------------------------------------------------------
// heater_hysteresis_control_unit: hot-water tank heater on/off control
// Hysteresis control with interlocks, startup wait, level-recovery delay
// and over-temperature cutoff; one input transfer per one-second tick.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one transfer per tick carrying the tank temperature and
//   the status flags. m_* channel: one result transfer per tick with the
//   heater command, selected thresholds and remaining counter values.
//   APB port: four registers at byte addresses 0, 4, 8, 12 (heating
//   enable, boost mode, altitude level, protect temperature); pready is
//   tied high and a write lands on the access cycle. Write only while idle.
// Timing
//   Two register stages: input register, then result register. A result
//   is offered on m_tvalid once its item has passed the input register
//   into the result register. One transfer per cycle is sustained while
//   m_tready is high; the tick state update is a single compare/decrement
//   pass, so only output stalls hold throughput below one item per clock.
// Reset
//   Synchronous, active high. Startup wait reloads to STARTUP_TICKS, the
//   level delay to LEVEL_DELAY_TICKS, heater off, level treated as low;
//   registers to their defaults (protect temperature 95.0 degC).
// Back-pressure
//   While m_tready is low the result holds; one more input is taken into
//   the input register, after which s_tready drops.
// ----------------------------------------------------------------------------
module heater_hysteresis_control_unit
  import hhc_pkg::*;
#(
  parameter int STARTUP_TICKS     = 5,
  parameter int LEVEL_DELAY_TICKS = 60
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // tank_temp[11:0], level_low[12], tank_error[13], dispensing[14],
  // flushing[15], cancel_delay[16], zero fill[23:17]
  input  logic [23:0] s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // heater_on[0], on_threshold[11:1], off_threshold[22:12],
  // delay_left[28:23], startup_left[31:29]
  output logic [31:0] m_tdata
);

  localparam int SW_RAW = $clog2(STARTUP_TICKS + 1);
  localparam int DW_RAW = $clog2(LEVEL_DELAY_TICKS + 1);
  // counters keep at least the width shown on the result bus
  localparam int SW     = (SW_RAW < 3) ? 3 : SW_RAW;
  localparam int DW     = (DW_RAW < 6) ? 6 : DW_RAW;

  // configuration registers
  hhc_cfg_t      cfg;
  logic          cfg_write;

  // tick state
  logic [SW-1:0] startup;
  logic [DW-1:0] delay;
  logic          heating;
  logic          prev_level_low;
  logic [SW-1:0] startup_next;
  logic [DW-1:0] delay_next;
  logic          heating_next;
  logic          prev_level_low_next;

  // input stage
  logic          in_valid;
  hhc_item_t     in_item;
  hhc_result_t   result;

  logic          s_transfer;
  logic          advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heating_enable <= 1'b0;
      cfg.boost_mode     <= 1'b0;
      cfg.altitude_level <= 2'd0;
      cfg.protect_temp   <= PROTECT_TEMP_RESET;
    end else if (cfg_write) begin
      unique case (hhc_reg_t'(paddr[3:2]))
        REG_HEATING_ENABLE: cfg.heating_enable <= pwdata[0];
        REG_BOOST_MODE:     cfg.boost_mode     <= pwdata[0];
        REG_ALTITUDE_LEVEL: cfg.altitude_level <= pwdata[1:0];
        REG_PROTECT_TEMP:   cfg.protect_temp   <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (hhc_reg_t'(paddr[3:2]))
      REG_HEATING_ENABLE: prdata = {31'd0, cfg.heating_enable};
      REG_BOOST_MODE:     prdata = {31'd0, cfg.boost_mode};
      REG_ALTITUDE_LEVEL: prdata = {30'd0, cfg.altitude_level};
      REG_PROTECT_TEMP:   prdata = {21'd0, cfg.protect_temp};
    endcase
  end

  // The input stage moves on whenever the result register is free or
  // being emptied; a new transfer is taken whenever the input stage
  // is empty or moving on.
  assign advance    = in_valid && (!m_tvalid || m_tready);
  assign s_tready   = !in_valid || advance;
  assign s_transfer = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_transfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_transfer) begin
      in_item <= hhc_item_t'(s_tdata[16:0]);
    end
  end

  hhc_core #(
    .LEVEL_DELAY_TICKS (LEVEL_DELAY_TICKS),
    .SW                (SW),
    .DW                (DW)
  ) u_core (
    .cfg                 (cfg),
    .item                (in_item),
    .startup             (startup),
    .delay               (delay),
    .heating             (heating),
    .prev_level_low      (prev_level_low),
    .startup_next        (startup_next),
    .delay_next          (delay_next),
    .heating_next        (heating_next),
    .prev_level_low_next (prev_level_low_next),
    .result              (result)
  );

  // tick state commits only when its item reaches the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      startup        <= SW'(STARTUP_TICKS);
      delay          <= DW'(LEVEL_DELAY_TICKS);
      heating        <= 1'b0;
      prev_level_low <= 1'b1;
    end else if (advance) begin
      startup        <= startup_next;
      delay          <= delay_next;
      heating        <= heating_next;
      prev_level_low <= prev_level_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= result;
    end
  end

endmodule

### design/hhc_checker.sv
// ----------------------------------------------------------------------------
// hhc_checker: port-level checks for the heater hysteresis control
// Watches the result stream and flags illegal combinations over time.
// ----------------------------------------------------------------------------
module hhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // nothing is offered straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // heater may only run once startup wait and level delay have expired
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[28:23] == 6'd0) && (m_tdata[31:29] == 3'd0))
    else $error("heater on while a wait is still running");

  // hysteresis band is never inverted
  a_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:1] < m_tdata[22:12]))
    else $error("on threshold not below off threshold");

endmodule

bind heater_hysteresis_control_unit hhc_checker u_hhc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
